@@ hw/rtl/auf_pkg.sv @@
// Shared types and constants of the advertising data UUID128 filter.
package auf_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned AddrW = 4;
  localparam int unsigned UuidW = 128;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] total_len;
    logic       last;
  } item_t;

endpackage

@@ hw/rtl/auf_if.sv @@
// Valid-ready channel interfaces for payload bytes and filter results.
interface auf_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] total_len;
  logic       last;

  modport source (output valid, output data_byte, output total_len, output last, input ready);
  modport sink (input valid, input data_byte, input total_len, input last, output ready);
endinterface

interface auf_result_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, output found, input ready);
  modport sink (input valid, input found, output ready);
endinterface

@@ hw/rtl/auf_cfg_regs.sv @@
// APB register file holding the 128-bit UUID.
module auf_cfg_regs import auf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [UuidW-1:0] uuid_o
);

  localparam logic RegUuidLow  = 1'b0;
  localparam logic RegUuidHigh = 1'b1;

  logic [DataW-1:0] uuid_low_q;
  logic [DataW-1:0] uuid_high_q;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uuid_low_q  <= '0;
      uuid_high_q <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegUuidLow:  uuid_low_q  <= pwdata;
        RegUuidHigh: uuid_high_q <= pwdata;
        default:     uuid_low_q  <= uuid_low_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegUuidLow:  prdata = uuid_low_q;
      RegUuidHigh: prdata = uuid_high_q;
      default:     prdata = '0;
    endcase
  end

  assign uuid_o = {uuid_high_q, uuid_low_q};

endmodule

@@ hw/rtl/auf_in_stage.sv @@
// Input register stage for payload bytes.
module auf_in_stage import auf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  auf_item_if.sink in_item,
  output logic  valid_o,
  output item_t item_o,
  input  logic  take_i
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  accept;

  assign in_item.ready = !valid_q || take_i;
  assign accept        = in_item.valid && in_item.ready;
  assign valid_d       = accept || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{data_byte: in_item.data_byte, total_len: in_item.total_len,
                  last: in_item.last};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/auf_parser.sv @@
// Length-type-value parser, UUID window compare and result register.
module auf_parser import auf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [UuidW-1:0] uuid_i,
  input  logic             valid_i,
  input  item_t            item_i,
  output logic             take_o,
  auf_result_if.source     out_res
);

  typedef enum logic [3:0] {
    PhLen   = 4'b0001,
    PhType  = 4'b0010,
    PhValue = 4'b0100,
    PhStop  = 4'b1000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] byte_pos_q, byte_pos_d;
  logic [7:0] left_q, left_d;
  logic       type_q, type_d;
  logic [3:0] win_pos_q, win_pos_d;
  logic       mismatch_q, mismatch_d;
  logic       seen_q, seen_d;
  logic       res_valid_q, res_valid_d;
  logic       res_found_q;
  logic       take;
  logic [8:0] end_pos;
  logic [7:0] left_dec;
  logic       mismatch_now;
  logic [7:0] uuid_byte;

  assign take     = valid_i && (!item_i.last || !res_valid_q || out_res.ready);
  assign take_o   = take;
  assign end_pos  = {1'b0, byte_pos_q} + {1'b0, item_i.data_byte} + 9'd1;
  assign left_dec = left_q - 8'd1;
  assign uuid_byte = uuid_i[{win_pos_q, 3'b000} +: 8];
  assign mismatch_now = mismatch_q || (item_i.data_byte != uuid_byte);

  always_comb begin
    phase_d    = phase_q;
    byte_pos_d = byte_pos_q;
    left_d     = left_q;
    type_d     = type_q;
    win_pos_d  = win_pos_q;
    mismatch_d = mismatch_q;
    seen_d     = seen_q;
    if (take) begin
      if (!seen_q) begin
        unique case (phase_q)
          PhLen: begin
            if (byte_pos_q >= item_i.total_len || item_i.data_byte == 8'd0 ||
                end_pos > {1'b0, item_i.total_len}) begin
              phase_d = PhStop;
            end else begin
              left_d  = item_i.data_byte;
              phase_d = PhType;
            end
          end
          PhType: begin
            type_d     = (item_i.data_byte == 8'h06) || (item_i.data_byte == 8'h07);
            left_d     = left_dec;
            win_pos_d  = '0;
            mismatch_d = 1'b0;
            phase_d    = (left_dec != 8'd0) ? PhValue : PhLen;
          end
          PhValue: begin
            if (type_q) begin
              if (win_pos_q == 4'd15) begin
                if (!mismatch_now) begin
                  seen_d = 1'b1;
                end
                win_pos_d  = '0;
                mismatch_d = 1'b0;
              end else begin
                win_pos_d  = win_pos_q + 4'd1;
                mismatch_d = mismatch_now;
              end
            end
            left_d = left_dec;
            if (left_dec == 8'd0) begin
              phase_d = PhLen;
            end
          end
          PhStop: begin
            phase_d = PhStop;
          end
          default: begin
            phase_d = PhStop;
          end
        endcase
      end
      if (byte_pos_q != 8'd255) begin
        byte_pos_d = byte_pos_q + 8'd1;
      end
      if (item_i.last) begin
        phase_d    = PhLen;
        byte_pos_d = '0;
        left_d     = '0;
        type_d     = 1'b0;
        win_pos_d  = '0;
        mismatch_d = 1'b0;
        seen_d     = 1'b0;
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q && !out_res.ready;
    if (take && item_i.last) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLen;
      byte_pos_q  <= '0;
      left_q      <= '0;
      type_q      <= 1'b0;
      win_pos_q   <= '0;
      mismatch_q  <= 1'b0;
      seen_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      byte_pos_q  <= byte_pos_d;
      left_q      <= left_d;
      type_q      <= type_d;
      win_pos_q   <= win_pos_d;
      mismatch_q  <= mismatch_d;
      seen_q      <= seen_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      res_found_q <= (phase_q == PhValue && !seen_q && type_q && win_pos_q == 4'd15 &&
                      !mismatch_now) || seen_q;
    end
  end

  assign out_res.valid = res_valid_q;
  assign out_res.found = res_found_q;

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_i.last |=> res_valid_q && byte_pos_q == 8'd0 && !seen_q)
    else $error("Parser state not cleared after the last byte.");

  a_type_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhType || phase_q == PhValue) |-> left_q != 8'd0)
    else $error("Structure has no bytes left while inside it.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !out_res.ready |-> !(take && item_i.last))
    else $error("Pending result would be overwritten.");

  a_seen_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q && !(take && item_i.last) |=> seen_q)
    else $error("Match flag dropped within a payload.");
`endif

endmodule

@@ hw/rtl/adv_data_uuid128_filter_core.sv @@
// Top level of the advertising data UUID128 filter.
//
//   Channel   Dir  Handshake      Payload
//   in_item   in   valid/ready    data_byte[7:0], total_len[7:0], last
//   out_res   out  valid/ready    found
//   APB       in   psel/penable   paddr[3:0], pwdata/prdata[63:0]; UUID low at 0, high at 8
//
// One byte transaction is accepted every cycle while the input register is not
// stalled; the parser updates its state from the byte in the input register, and
// a last byte that leaves the input register sets the registered result.
// A result that is not taken stalls the next last byte in the input register,
// and with it the input. Other bytes pass a held result without stalling.
// Reset clears the UUID registers and the parser; there is no clearing pass.
module adv_data_uuid128_filter_core import auf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  auf_item_if.sink         in_item,
  auf_result_if.source     out_res,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [UuidW-1:0] uuid;
  logic             st_valid;
  item_t            st_item;
  logic             st_take;

  auf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .uuid_o  (uuid)
  );

  auf_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_item (in_item),
    .valid_o (st_valid),
    .item_o  (st_item),
    .take_i  (st_take)
  );

  auf_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .uuid_i  (uuid),
    .valid_i (st_valid),
    .item_i  (st_item),
    .take_o  (st_take),
    .out_res (out_res)
  );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the advertising data UUID128 filter core.
module tb;
  import auf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [AddrW-1:0] ADDR_UUID_LO = 4'h0;
  localparam logic [AddrW-1:0] ADDR_UUID_HI = 4'h8;
  localparam logic [7:0] AD_UUID128_PART = 8'h06;
  localparam logic [7:0] AD_UUID128_FULL = 8'h07;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  typedef enum logic [1:0] {SEEK_LEN, SEEK_TYPE, IN_VALUE, HALTED} scan_phase_e;
  typedef enum int {
    PL_WELL, PL_SHORT_TL, PL_ZERO_LEN, PL_EARLY_LAST, PL_LATE_LAST, PL_TL_DRIFT, PL_NOISE,
    PL_LONG
  } payload_kind_e;

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  auf_item_if   byte_ch ();
  auf_result_if res_ch ();

  adv_data_uuid128_filter_core u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_item (byte_ch),
    .out_res (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [UuidW-1:0] uuid_model;
  logic [7:0]       scan_pos;
  logic [7:0]       scan_left;
  scan_phase_e      scan_phase;
  logic             uuid_type;
  logic [3:0]       win_idx;
  logic             win_bad;
  logic             scan_hit;

  item_t      pend_q[$];
  logic       found_due_q[$];
  logic [7:0] adv_buf[$];
  item_t      cur_item;
  int         bytes_queued;
  int         fail_count;
  int         src_gap;
  int         snk_gap;
  int         snk_hold;
  int         hold_requests;
  int         hold_served;
  int         quiet_cycles;
  bit         src_idle;
  bit         snk_idle;
  bit         drv_busy;
  bit         snk_ready;
  logic       want;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap(input bit idle);
    return (idle && $urandom_range(0, 1) == 1) ? $urandom_range(0, 17) : 0;
  endfunction

  function automatic void clear_scan();
    scan_pos = 8'd0;
    scan_left = 8'd0;
    scan_phase = SEEK_LEN;
    uuid_type = 1'b0;
    win_idx = 4'd0;
    win_bad = 1'b0;
    scan_hit = 1'b0;
  endfunction

  task automatic track_byte(input item_t it);
    logic [7:0] d;
    d = it.data_byte;
    if (!scan_hit && scan_phase != HALTED) begin
      case (scan_phase)
        SEEK_LEN: begin
          if (scan_pos >= it.total_len || d == 8'd0 ||
              (int'(scan_pos) + int'(d) + 1) > int'(it.total_len)) begin
            scan_phase = HALTED;
          end else begin
            scan_left = d;
            scan_phase = SEEK_TYPE;
          end
        end
        SEEK_TYPE: begin
          uuid_type = (d == AD_UUID128_PART || d == AD_UUID128_FULL);
          scan_left = scan_left - 8'd1;
          win_idx = 4'd0;
          win_bad = 1'b0;
          scan_phase = (scan_left != 8'd0) ? IN_VALUE : SEEK_LEN;
        end
        default: begin
          if (uuid_type) begin
            if (d != uuid_model[{win_idx, 3'b000} +: 8]) begin
              win_bad = 1'b1;
            end
            if (win_idx == 4'd15) begin
              if (!win_bad) begin
                scan_hit = 1'b1;
              end
              win_idx = 4'd0;
              win_bad = 1'b0;
            end else begin
              win_idx = win_idx + 4'd1;
            end
          end
          scan_left = scan_left - 8'd1;
          if (scan_left == 8'd0) begin
            scan_phase = SEEK_LEN;
          end
        end
      endcase
    end
    if (scan_pos != 8'hFF) begin
      scan_pos = scan_pos + 8'd1;
    end
    if (it.last) begin
      found_due_q.push_back(scan_hit);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      drv_busy = byte_ch.valid;
      if (byte_ch.valid && byte_ch.ready) begin
        track_byte(cur_item);
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pend_q.size() != 0) begin
          cur_item = pend_q.pop_front();
          byte_ch.data_byte <= cur_item.data_byte;
          byte_ch.total_len <= cur_item.total_len;
          byte_ch.last <= cur_item.last;
          drv_busy = 1'b1;
          src_gap = draw_gap(src_idle);
        end
      end
      byte_ch.valid <= drv_busy;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        if (found_due_q.size() == 0) begin
          $error("found: expected no transaction, actual %0b", res_ch.found);
          fail_count++;
        end else begin
          want = found_due_q.pop_front();
          if (res_ch.found !== want) begin
            $error("found: expected %0b, actual %0b", want, res_ch.found);
            fail_count++;
          end
        end
        snk_gap = draw_gap(snk_idle);
      end else if (snk_gap > 0) begin
        snk_gap--;
      end
      if (hold_requests != hold_served) begin
        hold_served++;
        snk_hold = LONG_HOLD;
      end else if (snk_hold > 0) begin
        snk_hold--;
      end
      snk_ready = (snk_gap == 0) && (snk_hold == 0);
      res_ch.ready <= snk_ready;
    end
  end

  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== data) begin
      $error("prdata: expected %h, actual %h", data, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_uuid(input logic [63:0] lo, input logic [63:0] hi);
    apb_write(ADDR_UUID_LO, lo);
    apb_write(ADDR_UUID_HI, hi);
    uuid_model = {hi, lo};
    apb_check(ADDR_UUID_LO, lo);
    apb_check(ADDR_UUID_HI, hi);
  endtask

  task automatic settle();
    @(negedge clk);
    while (pend_q.size() != 0 || byte_ch.valid || found_due_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic void queue_adv(input logic [7:0] tl, input bit drift);
    item_t it;
    int    i;
    for (i = 0; i < adv_buf.size(); i++) begin
      it.data_byte = adv_buf[i];
      it.total_len = drift ? 8'($urandom_range(1, 255)) : tl;
      it.last = (i == adv_buf.size() - 1);
      pend_q.push_back(it);
    end
    bytes_queued += adv_buf.size();
  endfunction

  function automatic void add_uuid_ad(input int nwin, input int tail, input bit spoil);
    int         hit;
    int         w;
    int         b;
    int         flip_at;
    logic [7:0] flip;
    hit = $urandom_range(0, nwin - 1);
    adv_buf.push_back(8'(1 + 16 * nwin + tail));
    adv_buf.push_back(($urandom_range(0, 1) == 1) ? AD_UUID128_FULL : AD_UUID128_PART);
    for (w = 0; w < nwin; w++) begin
      flip_at = (w != hit || spoil) ? $urandom_range(0, 15) : -1;
      flip = 8'($urandom_range(1, 255));
      for (b = 0; b < 16; b++) begin
        adv_buf.push_back(uuid_model[b*8 +: 8] ^ ((b == flip_at) ? flip : 8'h00));
      end
    end
    for (b = 0; b < tail; b++) begin
      adv_buf.push_back(uuid_model[b*8 +: 8]);
    end
  endfunction

  function automatic void add_plain_ad(input int vlen, input bit uuid_fill);
    logic [7:0] t;
    int         i;
    do begin
      t = 8'($urandom_range(0, 255));
    end while (t == AD_UUID128_PART || t == AD_UUID128_FULL);
    adv_buf.push_back(8'(vlen + 1));
    adv_buf.push_back(t);
    for (i = 0; i < vlen; i++) begin
      adv_buf.push_back(uuid_fill ? uuid_model[(i % 16)*8 +: 8] : 8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_random_ad();
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        add_uuid_ad(($urandom_range(0, 3) == 0) ? 2 : 1,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0,
                    $urandom_range(0, 3) == 0);
      end
      3: add_plain_ad($urandom_range(0, 3), 1'b0);
      4: add_plain_ad(16, 1'b1);
      default: add_plain_ad($urandom_range(0, 20), 1'b0);
    endcase
  endfunction

  function automatic payload_kind_e pick_kind();
    case ($urandom_range(0, 11))
      6: return PL_SHORT_TL;
      7: return PL_ZERO_LEN;
      8: return PL_EARLY_LAST;
      9: return PL_LATE_LAST;
      10: return PL_TL_DRIFT;
      11: return PL_NOISE;
      default: return PL_WELL;
    endcase
  endfunction

  function automatic void queue_payload(input payload_kind_e kind);
    int         nstruct;
    int         zpos;
    int         cut;
    int         i;
    logic [7:0] tl;
    adv_buf.delete();
    nstruct = $urandom_range(1, 3);
    zpos = $urandom_range(0, nstruct - 1);
    for (i = 0; i < nstruct || (kind == PL_LONG && adv_buf.size() < 240); i++) begin
      if (kind == PL_ZERO_LEN && i == zpos) begin
        adv_buf.push_back(8'h00);
      end
      add_random_ad();
    end
    if (kind == PL_NOISE) begin
      adv_buf.delete();
      repeat ($urandom_range(1, 40)) adv_buf.push_back(8'($urandom_range(0, 255)));
    end
    tl = 8'(adv_buf.size());
    case (kind)
      PL_SHORT_TL: tl = 8'($urandom_range(1, adv_buf.size()));
      PL_EARLY_LAST: begin
        cut = $urandom_range(1, adv_buf.size());
        while (adv_buf.size() > cut) adv_buf.delete(adv_buf.size() - 1);
      end
      PL_LATE_LAST: repeat ($urandom_range(1, 12)) adv_buf.push_back(8'($urandom_range(0, 255)));
      PL_NOISE: tl = 8'($urandom_range(1, 255));
      PL_LONG: begin
        tl = 8'd255;
        while (adv_buf.size() < 270) adv_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    queue_adv(tl, kind == PL_TL_DRIFT);
  endfunction

  task automatic run_phase(input logic [63:0] lo, input logic [63:0] hi, input int budget,
                           input bit src_slow, input bit snk_slow, input bit pressure);
    int stop_at;
    set_uuid(lo, hi);
    src_idle = src_slow;
    snk_idle = snk_slow;
    stop_at = bytes_queued + budget;
    if (pressure) begin
      queue_payload(PL_LONG);
      repeat (6) queue_payload(PL_WELL);
      hold_requests++;
    end
    while (bytes_queued < stop_at) queue_payload(pick_kind());
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'd0;
    byte_ch.total_len = 8'd1;
    byte_ch.last = 1'b0;
    res_ch.ready = 1'b0;
    uuid_model = '0;
    clear_scan();
    bytes_queued = 0;
    fail_count = 0;
    src_gap = 0;
    snk_gap = 0;
    snk_hold = 0;
    hold_requests = 0;
    hold_served = 0;
    quiet_cycles = 0;
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset UUID of all zeros, a value of sixteen zero bytes matches.
    adv_buf.delete();
    adv_buf.push_back(8'h11);
    adv_buf.push_back(AD_UUID128_PART);
    repeat (16) adv_buf.push_back(8'h00);
    queue_adv(8'd18, 1'b0);
    adv_buf.delete();
    adv_buf.push_back(8'h00);
    queue_adv(8'd1, 1'b0);
    adv_buf.delete();
    adv_buf.push_back(8'h05);
    adv_buf.push_back(8'hFF);
    queue_adv(8'd2, 1'b0);
    adv_buf.delete();
    adv_buf.push_back(8'h01);
    adv_buf.push_back(8'hFF);
    queue_adv(8'd255, 1'b0);
    adv_buf.delete();
    adv_buf.push_back(8'h01);
    adv_buf.push_back(AD_UUID128_FULL);
    adv_buf.push_back(8'h03);
    queue_adv(8'd2, 1'b0);
    settle();

    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 380, 1'b1, 1'b1, 1'b0);
    run_phase({64{1'b1}}, {$urandom, $urandom}, 400, 1'b0, 1'b1, 1'b1);
    run_phase('0, '0, 360, 1'b0, 1'b0, 1'b0);
    run_phase({$urandom, $urandom}, {64{1'b1}}, 380, 1'b1, 1'b1, 1'b0);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/auf_pkg.sv
hw/rtl/auf_if.sv
hw/rtl/auf_cfg_regs.sv
hw/rtl/auf_in_stage.sv
hw/rtl/auf_parser.sv
hw/rtl/adv_data_uuid128_filter_core.sv
verif/tb.sv
